// ----- hdl/tlfq_pkg.sv -----
// shared types, constants and codes for the two-level feedback queue scheduler
`default_nettype none

package tlfq_pkg;

    // sizing
    localparam int QUEUE_DEPTH  = 16;
    localparam int TASK_ID_BITS = 16;
    localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);
    localparam int QUANTUM_W    = 16;
    localparam int SLICE_W      = QUANTUM_W + 1;

    // reset value of the base quantum
    localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = QUANTUM_W'(1000);

    // operation codes
    localparam logic [1:0] OP_ADMIT    = 2'd0;
    localparam logic [1:0] OP_RUNNING  = 2'd1;
    localparam logic [1:0] OP_FINISHED = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NO_TASK  = 2'd2;

    // input item
    typedef struct packed {
        logic [1:0]              operation;
        logic [TASK_ID_BITS-1:0] task_id;
    } in_item_t;

    // result item
    typedef struct packed {
        logic                    dispatch_valid;
        logic [TASK_ID_BITS-1:0] dispatch_task;
        logic                    dispatch_level;
        logic [SLICE_W-1:0]      slice_length;
        logic [1:0]              status;
    } out_item_t;

    // queue request from the controller
    typedef struct packed {
        logic push;
        logic pop;
    } queue_ctrl_t;

    // per-cell control from the queue
    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- hdl/tlfq_cell.sv -----
// one storage cell of a shifting queue chain
`default_nettype none

module tlfq_cell
    import tlfq_pkg::*;
(
    input  wire logic                    clk,
    input  wire cell_ctrl_t              ctrl,
    input  wire logic [TASK_ID_BITS-1:0] load_data,
    input  wire logic [TASK_ID_BITS-1:0] neighbor_data,
    output logic      [TASK_ID_BITS-1:0] data
);

    logic [TASK_ID_BITS-1:0] data_reg;
    logic [TASK_ID_BITS-1:0] data_next;

    // load wins over shift: a rotate writes the last live cell after the shift
    always_comb
    begin
        priority if (ctrl.load)
        begin
            data_next = load_data;
        end
        else if (ctrl.shift)
        begin
            data_next = neighbor_data;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

// ----- hdl/tlfq_queue.sv -----
// shifting queue: a chain of cells with the head always in cell zero
`default_nettype none

module tlfq_queue
    import tlfq_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire queue_ctrl_t             ctrl,
    input  wire logic [TASK_ID_BITS-1:0] push_data,
    output logic      [TASK_ID_BITS-1:0] head,
    output logic      [CNT_W-1:0]        count
);

    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic [CNT_W-1:0]        load_pos;
    logic [TASK_ID_BITS-1:0] cell_data [QUEUE_DEPTH];

    // new entry lands just past the live cells, after any shift
    always_comb
    begin
        if (ctrl.pop)
        begin
            load_pos = count_reg - CNT_W'(1);
        end
        else
        begin
            load_pos = count_reg;
        end
    end

    // fill count
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.push && !ctrl.pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.pop && !ctrl.push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // cell chain, each cell takes its right neighbor on a pop
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        cell_ctrl_t              cc;
        logic [TASK_ID_BITS-1:0] nb;

        assign cc.load  = ctrl.push && (load_pos == CNT_W'(i));
        assign cc.shift = ctrl.pop;

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign nb = cell_data[i];
        end
        else
        begin : g_mid
            assign nb = cell_data[i + 1];
        end

        tlfq_cell u_cell (
            .clk           (clk),
            .ctrl          (cc),
            .load_data     (push_data),
            .neighbor_data (nb),
            .data          (cell_data[i])
        );
    end

    assign head  = cell_data[0];
    assign count = count_reg;

endmodule

`default_nettype wire

// ----- hdl/two_level_feedback_queue_scheduler_unit.sv -----
// top level of the two-level feedback queue scheduler
`default_nettype none

// Two-level feedback queue dispatcher. Each accepted item (admit, slice end
// with the task still running, slice end with the task finished, or an
// unused code, which moves nothing) updates the two queues in the cycle it is
// accepted, and its result is offered on the next cycle; with out_ready held
// high one item is taken every clock. in_ready drops only while a result waits
// to be taken. Both queues are chains of shifting cells with the head fixed in
// the first cell, so a pop, a push and a lower-queue rotation each finish in the
// accepting cycle; no reset sweep is needed. Dispatch fields come straight
// from the queue heads, fixed while a result waits, and the quantum register.
// base_quantum may be written only while the block is idle.

module two_level_feedback_queue_scheduler_unit
    import tlfq_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire in_item_t             in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output out_item_t                 out_data,
    input  wire logic                 cfg_we,
    input  wire logic [QUANTUM_W-1:0] cfg_data
);

    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [1:0]              status_reg;
    logic [1:0]              status_next;
    logic [QUANTUM_W-1:0]    quantum_reg;
    logic [QUANTUM_W-1:0]    quantum_next;

    logic                    accept;
    queue_ctrl_t             up_ctrl;
    queue_ctrl_t             lo_ctrl;
    logic [TASK_ID_BITS-1:0] up_head;
    logic [TASK_ID_BITS-1:0] lo_head;
    logic [CNT_W-1:0]        up_count;
    logic [CNT_W-1:0]        lo_count;
    logic [TASK_ID_BITS-1:0] lo_push_data;
    logic [CNT_W:0]          total;
    logic                    up_busy;
    logic                    lo_busy;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign up_busy  = (up_count != '0);
    assign lo_busy  = (lo_count != '0);
    assign total    = {1'b0, up_count} + {1'b0, lo_count};

    // decode the item into queue moves
    always_comb
    begin
        up_ctrl      = '0;
        lo_ctrl      = '0;
        lo_push_data = up_head;
        status_next  = status_reg;
        if (accept)
        begin
            status_next = ST_OK;
            unique case (in_data.operation)
                OP_ADMIT:
                begin
                    if (total >= (CNT_W + 1)'(QUEUE_DEPTH))
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        up_ctrl.push = 1'b1;
                    end
                end
                OP_RUNNING, OP_FINISHED:
                begin
                    priority if (up_busy)
                    begin
                        // upper task leaves; demoted if still running
                        up_ctrl.pop  = 1'b1;
                        lo_ctrl.push = (in_data.operation == OP_RUNNING);
                        lo_push_data = up_head;
                    end
                    else if (lo_busy)
                    begin
                        // lower task leaves; rotates to the tail if running
                        lo_ctrl.pop  = 1'b1;
                        lo_ctrl.push = (in_data.operation == OP_RUNNING);
                        lo_push_data = lo_head;
                    end
                    else
                    begin
                        status_next = ST_NO_TASK;
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    // result slot and quantum register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        quantum_next = cfg_we ? cfg_data : quantum_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
            quantum_reg   <= QUANTUM_RESET;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            quantum_reg   <= quantum_next;
        end
    end

    // upper queue
    tlfq_queue u_upper (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (up_ctrl),
        .push_data (in_data.task_id),
        .head      (up_head),
        .count     (up_count)
    );

    // lower queue
    tlfq_queue u_lower (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (lo_ctrl),
        .push_data (lo_push_data),
        .head      (lo_head),
        .count     (lo_count)
    );

    // next dispatch from the queue heads
    always_comb
    begin
        out_data        = '0;
        out_data.status = status_reg;
        priority if (up_busy)
        begin
            out_data.dispatch_valid = 1'b1;
            out_data.dispatch_task  = up_head;
            out_data.dispatch_level = 1'b0;
            out_data.slice_length   = {1'b0, quantum_reg};
        end
        else if (lo_busy)
        begin
            out_data.dispatch_valid = 1'b1;
            out_data.dispatch_task  = lo_head;
            out_data.dispatch_level = 1'b1;
            out_data.slice_length   = {quantum_reg, 1'b0};
        end
        else
        begin
            out_data.dispatch_valid = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ----- dv/tb_two_level_feedback_queue_scheduler_unit.sv -----
// testbench for the two-level feedback queue scheduler: directed table, random traffic, predictor
`timescale 1ns / 100ps

module tb_two_level_feedback_queue_scheduler_unit;
    import tlfq_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         PHASES      = 5;
    localparam int         PHASE_ITEMS = 250;
    localparam int         CHUNK       = 32;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         DIR_ROWS    = 24;

    // one row of the directed table; typed rows carry the result to expect
    typedef struct packed {
        in_item_t  item;
        logic      typed;
        out_item_t want;
    } directed_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    in_item_t             in_data;
    logic                 out_valid;
    logic                 out_ready;
    out_item_t            out_data;
    logic                 cfg_we;
    logic [QUANTUM_W-1:0] cfg_data;

    // predictor state
    logic [TASK_ID_BITS-1:0] upper_ids [QUEUE_DEPTH];
    logic [TASK_ID_BITS-1:0] lower_ids [QUEUE_DEPTH];
    int                      up_head, up_tail, up_cnt;
    int                      lo_head, lo_tail, lo_cnt;
    logic [QUANTUM_W-1:0]    quantum;

    out_item_t pending_dispatch [$];
    int        error_count;
    int        cycle_count;
    bit        send_idle;
    bit        recv_idle;

    directed_row_t directed_rows [DIR_ROWS] = '{
        // slice ends and an unused code with nothing held
        '{'{OP_RUNNING, 16'h0000}, 1'b1, '{1'b0, 16'h0000, 1'b0, 17'd0, ST_NO_TASK}},
        '{'{OP_FINISHED, 16'h0000}, 1'b1, '{1'b0, 16'h0000, 1'b0, 17'd0, ST_NO_TASK}},
        '{'{OP_UNUSED, 16'h1234}, 1'b1, '{1'b0, 16'h0000, 1'b0, 17'd0, ST_OK}},
        // widest and narrowest ids, then demotion and lower-queue rotation
        '{'{OP_ADMIT, 16'hFFFF}, 1'b1, '{1'b1, 16'hFFFF, 1'b0, {1'b0, QUANTUM_RESET}, ST_OK}},
        '{'{OP_ADMIT, 16'h0000}, 1'b0, '0},
        '{'{OP_RUNNING, 16'h0000}, 1'b0, '0},
        '{'{OP_RUNNING, 16'h0000}, 1'b0, '0},
        '{'{OP_RUNNING, 16'h0000}, 1'b0, '0},
        // fill the block with walking-one ids
        '{'{OP_ADMIT, 16'h0001}, 1'b0, '0},
        '{'{OP_ADMIT, 16'h0002}, 1'b0, '0},
        '{'{OP_ADMIT, 16'h0004}, 1'b0, '0},
        '{'{OP_ADMIT, 16'h0008}, 1'b0, '0},
        '{'{OP_ADMIT, 16'h0010}, 1'b0, '0},
        '{'{OP_ADMIT, 16'h0020}, 1'b0, '0},
        '{'{OP_ADMIT, 16'h0040}, 1'b0, '0},
        '{'{OP_ADMIT, 16'h0080}, 1'b0, '0},
        '{'{OP_ADMIT, 16'h0100}, 1'b0, '0},
        '{'{OP_ADMIT, 16'h0200}, 1'b0, '0},
        '{'{OP_ADMIT, 16'h0400}, 1'b0, '0},
        '{'{OP_ADMIT, 16'h0800}, 1'b0, '0},
        '{'{OP_ADMIT, 16'h1000}, 1'b0, '0},
        '{'{OP_ADMIT, 16'h2000}, 1'b0, '0},
        // admit refused while full
        '{'{OP_ADMIT, 16'h5A5A}, 1'b1, '{1'b1, 16'h0001, 1'b0, {1'b0, QUANTUM_RESET}, ST_FULL}},
        '{'{OP_FINISHED, 16'h0000}, 1'b0, '0}
    };

    two_level_feedback_queue_scheduler_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // expected dispatch after one item, updating the predictor queues
    task automatic schedule_step(input in_item_t it, output out_item_t res);
        logic [TASK_ID_BITS-1:0] moved;
        logic [1:0]              st;
        st = ST_OK;
        if (it.operation == OP_ADMIT)
        begin
            if (up_cnt + lo_cnt >= QUEUE_DEPTH)
                st = ST_FULL;
            else
            begin
                upper_ids[up_tail] = it.task_id;
                up_tail = (up_tail + 1) % QUEUE_DEPTH;
                up_cnt++;
            end
        end
        else if (it.operation == OP_RUNNING || it.operation == OP_FINISHED)
        begin
            if (up_cnt != 0 || lo_cnt != 0)
            begin
                if (up_cnt != 0)
                begin
                    moved = upper_ids[up_head];
                    up_head = (up_head + 1) % QUEUE_DEPTH;
                    up_cnt--;
                end
                else
                begin
                    moved = lower_ids[lo_head];
                    lo_head = (lo_head + 1) % QUEUE_DEPTH;
                    lo_cnt--;
                end
                // still running: demote or rotate to the lower tail
                if (it.operation == OP_RUNNING)
                begin
                    lower_ids[lo_tail] = moved;
                    lo_tail = (lo_tail + 1) % QUEUE_DEPTH;
                    lo_cnt++;
                end
            end
            else
                st = ST_NO_TASK;
        end
        res = '0;
        if (up_cnt != 0)
        begin
            res.dispatch_valid = 1'b1;
            res.dispatch_task  = upper_ids[up_head];
            res.slice_length   = {1'b0, quantum};
        end
        else if (lo_cnt != 0)
        begin
            res.dispatch_valid = 1'b1;
            res.dispatch_task  = lower_ids[lo_head];
            res.dispatch_level = 1'b1;
            res.slice_length   = {quantum, 1'b0};
        end
        res.status = st;
    endtask

    // offer one item, wait for acceptance, then queue its expected dispatch
    task automatic send_item(input in_item_t it, input logic typed, input out_item_t want);
        int unsigned gap;
        out_item_t   predicted;
        gap = send_idle ? $urandom_range(0, 5) : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        schedule_step(it, predicted);
        pending_dispatch.push_back(typed ? want : predicted);
    endtask

    // hold off until every dispatch is back, then load a new quantum
    task automatic write_quantum(input logic [QUANTUM_W-1:0] value);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_dispatch.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
        quantum = value;
    endtask

    // result side: random stalls, compare each dispatch with the oldest expected
    initial
    begin
        int unsigned gap;
        out_item_t   got;
        out_item_t   want;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = recv_idle ? $urandom_range(0, 5) : 0;
            @(negedge clk);
            if (gap != 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (out_valid !== 1'b1)
                @(posedge clk);
            got = out_data;
            if (pending_dispatch.size() == 0)
            begin
                $error("dispatch item with no input item outstanding");
                error_count++;
            end
            else
            begin
                want = pending_dispatch.pop_front();
                if (got.dispatch_valid !== want.dispatch_valid)
                begin
                    $error("dispatch_valid: expected %0d, got %0d",
                           want.dispatch_valid, got.dispatch_valid);
                    error_count++;
                end
                if (got.dispatch_task !== want.dispatch_task)
                begin
                    $error("dispatch_task: expected %h, got %h",
                           want.dispatch_task, got.dispatch_task);
                    error_count++;
                end
                if (got.dispatch_level !== want.dispatch_level)
                begin
                    $error("dispatch_level: expected %0d, got %0d",
                           want.dispatch_level, got.dispatch_level);
                    error_count++;
                end
                if (got.slice_length !== want.slice_length)
                begin
                    $error("slice_length: expected %0d, got %0d",
                           want.slice_length, got.slice_length);
                    error_count++;
                end
                if (got.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    error_count++;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        in_item_t             it;
        logic [QUANTUM_W-1:0] q_val;
        int                   sent;
        int                   item_no;
        int unsigned          r;
        int unsigned          admit_pct;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_we      = 1'b0;
        cfg_data    = '0;
        error_count = 0;
        cycle_count = 0;
        send_idle   = 1'b1;
        recv_idle   = 1'b1;
        up_head = 0; up_tail = 0; up_cnt = 0;
        lo_head = 0; lo_tail = 0; lo_cnt = 0;
        quantum = QUANTUM_RESET;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table at the reset quantum
        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

        // random phases, each under its own quantum
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       q_val = '0;
                1:       q_val = '1;
                2:       q_val = QUANTUM_W'(1);
                default: q_val = QUANTUM_W'($urandom_range(2, 65534));
            endcase
            write_quantum(q_val);
            sent      = 0;
            item_no   = 0;
            admit_pct = 50;
            while (sent < PHASE_ITEMS)
            begin
                // each chunk leans toward filling or draining, with its own idling
                if (item_no % CHUNK == 0)
                begin
                    admit_pct = $urandom_range(0, 1) ? 70 : 30;
                    send_idle = ($urandom_range(0, 3) != 0);
                    recv_idle = ($urandom_range(0, 3) != 0);
                end
                r = $urandom_range(0, 99);
                it.task_id = TASK_ID_BITS'($urandom_range(0, 65535));
                if (r < 3)
                    it.operation = OP_UNUSED;
                else if (r < 3 + admit_pct)
                    it.operation = OP_ADMIT;
                else if (r[0])
                    it.operation = OP_RUNNING;
                else
                    it.operation = OP_FINISHED;
                send_item(it, 1'b0, '0);
                item_no++;
                if (it.operation != OP_UNUSED)
                    sent++;
            end
        end

        // drain and let any stray result show up
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_dispatch.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/tlfq_pkg.sv
hdl/tlfq_cell.sv
hdl/tlfq_queue.sv
hdl/two_level_feedback_queue_scheduler_unit.sv
dv/tb_two_level_feedback_queue_scheduler_unit.sv
